[src/pfe_pkg.sv]
// Shared types and constants for the postfix expression evaluator.
// No dependencies; every other file of the block imports this package.
package pfe_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int SYMBOL_W        = 8;
    localparam int ANSWER_W        = 32;
    localparam int STATUS_W        = 3;

    localparam logic [SYMBOL_W-1:0] CH_END   = 8'h00;
    localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYMBOL_W-1:0] CH_CARET = 8'h5E;
    localparam logic [SYMBOL_W-1:0] CH_DIG0  = 8'd48;
    localparam logic [SYMBOL_W-1:0] CH_DIG9  = 8'd57;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_ZPOW  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SC_OTHER,
        SC_DIGIT,
        SC_OP,
        SC_END
    } t_sym_class;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } t_op;

    typedef enum logic [2:0] {
        RS_ADD,
        RS_SUB,
        RS_MUL,
        RS_DIV,
        RS_POW,
        RS_PNEG
    } t_res_sel;

    typedef enum logic [1:0] {
        MS_AB,
        MS_PR,
        MS_SQ
    } t_mul_src;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_POW,
        S_PMUL,
        S_PSQ,
        S_END
    } t_state;

    typedef struct packed {
        logic     load_sym;
        logic     prev_update;
        logic     digit_acc;
        logic     digit_push;
        logic     set_err;
        t_status  err_code;
        logic     rd_second;
        logic     pop;
        t_res_sel res_sel;
        logic     mul_load;
        t_mul_src mul_src;
        logic     div_load;
        logic     pow_load;
        logic     pr_take;
        logic     pb_take;
        logic     out_load;
        logic     end_clear;
    } t_dp_cmd;

    typedef struct packed {
        t_sym_class cls;
        t_op        op;
        logic       prev_digit;
        logic       err_nz;
        logic       empty;
        logic       full;
        logic       lt2;
        logic       b_zero;
        logic       b_neg;
        logic       a_zero;
        logic       mul_done;
        logic       div_done;
        logic       pe_zero;
        logic       pe_bit0;
        logic       pe_last;
    } t_dp_stat;

endpackage

[src/pfe_if.sv]
// Valid/ready channel interfaces: symbol requests in, answer requests out.
// Depends on pfe_pkg for the payload widths.
interface pfe_sym_if;
    import pfe_pkg::*;
    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface pfe_res_if;
    import pfe_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [ANSWER_W-1:0] answer;
    logic [STATUS_W-1:0]        status;
    modport source (output valid, output answer, output status, input ready);
    modport sink   (input valid, input answer, input status, output ready);
endinterface

[src/postfix_expression_evaluator.sv]
// Top level of the postfix (RPN) expression evaluator: controller plus datapath.
// Depends on pfe_pkg, pfe_if, pfe_ctrl and pfe_datapath.
//
//  channel  | dir | payload                      | notes
//  i_sym    | in  | symbol[7:0]                  | one ASCII character per request
//  o_res    | out | answer[31:0] s, status[2:0]  | one request per zero byte
//
// The * operator uses a shift-add multiplier that stops when the multiplier is
// used up, / a restoring divider (one bit a cycle), and ^ runs square-and-
// multiply over the exponent bits through the shared multiplier.
// Reset is synchronous and clears stack depth, digit flag, error and output valid.
// A finished answer waits in the output register while later symbols are taken;
// only the next zero byte stalls until that answer is taken.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = pfe_pkg::VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfe_sym_if.sink   i_sym,
    pfe_res_if.source o_res
);
    import pfe_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sym.valid),
        .o_in_ready  (i_sym.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pfe_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_symbol (i_sym.symbol),
        .o_answer (o_res.answer),
        .o_status (o_res.status)
    );

endmodule

[src/pfe_datapath.sv]
// Datapath: symbol register, top-of-stack register, stack RAM, shift-add
// multiplier, restoring divider, power sequencing registers, result register.
// Depends on pfe_pkg; driven by pfe_ctrl through t_dp_cmd / t_dp_stat.
module pfe_datapath #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = pfe_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pfe_pkg::t_dp_cmd                    i_cmd,
    output pfe_pkg::t_dp_stat                   o_stat,
    input  logic [pfe_pkg::SYMBOL_W-1:0]        i_symbol,
    output logic signed [pfe_pkg::ANSWER_W-1:0] o_answer,
    output logic [pfe_pkg::STATUS_W-1:0]        o_status
);
    import pfe_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [SYMBOL_W-1:0] r_sym;
    logic [DW-1:0]       r_depth;
    logic                r_prev;
    t_status             r_err;
    logic [W-1:0]        r_top;
    logic [W-1:0]        r_rd;
    logic [W-1:0]        r_mem [STACK_DEPTH];

    logic [W-1:0]  r_mx, r_my, r_mp;
    logic [W-1:0]  r_dq, r_drem, r_dd;
    logic [CW-1:0] r_dcnt;
    logic          r_dneg;
    logic [W-1:0]  r_pr, r_pb, r_pe;

    logic signed [ANSWER_W-1:0] r_answer;
    logic [STATUS_W-1:0]        r_status;

    t_sym_class   cls;
    t_op          op;
    logic [W-1:0] dval, acc_val, res;
    logic [W-1:0] ones;
    logic [DW-1:0] depth_m1, depth_m2;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [W-1:0] mul_x, mul_y;
    logic [W-1:0] div_sh;
    logic [W:0]   div_diff;
    logic [W-1:0] mag_a, mag_b, pneg_val;

    // symbol decode
    always_comb begin
        op = OP_ADD;
        if (r_sym == CH_END) begin
            cls = SC_END;
        end else if (r_sym >= CH_DIG0 && r_sym <= CH_DIG9) begin
            cls = SC_DIGIT;
        end else if (r_sym == CH_PLUS || r_sym == CH_MINUS || r_sym == CH_STAR ||
                     r_sym == CH_SLASH || r_sym == CH_CARET) begin
            cls = SC_OP;
        end else begin
            cls = SC_OTHER;
        end
        case (r_sym)
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            CH_CARET: op = OP_POW;
            default:  op = OP_ADD;
        endcase
    end

    assign ones     = '1;
    assign dval     = W'(r_sym[3:0]);
    assign acc_val  = (r_top << 3) + (r_top << 1) + dval;
    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);
    assign wr_addr  = depth_m1[AW-1:0];
    assign rd_addr  = depth_m2[AW-1:0];

    assign mag_a = r_rd[W-1]  ? (W'(0) - r_rd)  : r_rd;
    assign mag_b = r_top[W-1] ? (W'(0) - r_top) : r_top;

    // a negative exponent: only bases 1 and -1 give a nonzero result
    always_comb begin
        if (r_rd == W'(1)) begin
            pneg_val = W'(1);
        end else if (r_rd == ones) begin
            pneg_val = r_top[0] ? ones : W'(1);
        end else begin
            pneg_val = '0;
        end
    end

    always_comb begin
        case (i_cmd.mul_src)
            MS_AB:   begin mul_x = r_rd; mul_y = r_top; end
            MS_PR:   begin mul_x = r_pr; mul_y = r_pb;  end
            default: begin mul_x = r_pb; mul_y = r_pb;  end
        endcase
    end

    always_comb begin
        case (i_cmd.res_sel)
            RS_ADD:  res = r_rd + r_top;
            RS_SUB:  res = r_rd - r_top;
            RS_MUL:  res = r_mp;
            RS_DIV:  res = r_dneg ? (W'(0) - r_dq) : r_dq;
            RS_POW:  res = r_pr;
            default: res = pneg_val;
        endcase
    end

    // remainder stays below the divisor magnitude, so one bit of headroom is enough
    assign div_sh   = {r_drem[W-2:0], r_dq[W-1]};
    assign div_diff = {1'b0, div_sh} - {1'b0, r_dd};

    // stack RAM holds every entry below the top
    always_ff @(posedge i_clk) begin
        if (i_cmd.digit_push && r_depth != '0) begin
            r_mem[wr_addr] <= r_top;
        end
        if (i_cmd.rd_second) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_prev  <= 1'b0;
            r_err   <= ST_OK;
        end else if (i_cmd.end_clear) begin
            r_depth <= '0;
            r_prev  <= 1'b0;
            r_err   <= ST_OK;
        end else begin
            if (i_cmd.prev_update) begin
                r_prev <= (cls == SC_DIGIT);
            end
            if (i_cmd.set_err && r_err == ST_OK) begin
                r_err <= i_cmd.err_code;
            end
            if (i_cmd.digit_push) begin
                r_depth <= r_depth + DW'(1);
            end else if (i_cmd.pop) begin
                r_depth <= depth_m1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sym) begin
            r_sym <= i_symbol;
        end
        if (i_cmd.digit_acc) begin
            r_top <= acc_val;
        end else if (i_cmd.digit_push) begin
            r_top <= dval;
        end else if (i_cmd.pop) begin
            r_top <= res;
        end

        if (i_cmd.mul_load) begin
            r_mx <= mul_x;
            r_my <= mul_y;
            r_mp <= '0;
        end else if (r_my != '0) begin
            if (r_my[0]) begin
                r_mp <= r_mp + r_mx;
            end
            r_mx <= r_mx << 1;
            r_my <= r_my >> 1;
        end

        if (i_cmd.div_load) begin
            r_dq   <= mag_a;
            r_dd   <= mag_b;
            r_drem <= '0;
            r_dcnt <= CW'(VALUE_WIDTH);
            r_dneg <= r_rd[W-1] ^ r_top[W-1];
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - CW'(1);
            if (!div_diff[W]) begin
                r_drem <= div_diff[W-1:0];
                r_dq   <= {r_dq[W-2:0], 1'b1};
            end else begin
                r_drem <= div_sh;
                r_dq   <= {r_dq[W-2:0], 1'b0};
            end
        end

        if (i_cmd.pow_load) begin
            r_pr <= W'(1);
            r_pb <= r_rd;
            r_pe <= r_top;
        end else begin
            if (i_cmd.pr_take) begin
                r_pr <= r_mp;
            end
            if (i_cmd.pb_take) begin
                r_pb <= r_mp;
                r_pe <= r_pe >> 1;
            end
        end

        if (i_cmd.out_load) begin
            if (r_err != ST_OK || r_depth == '0) begin
                r_answer <= '0;
            end else begin
                r_answer <= ANSWER_W'(signed'(r_top));
            end
            if (r_err != ST_OK) begin
                r_status <= r_err;
            end else if (r_depth == '0) begin
                r_status <= ST_UNDER;
            end else begin
                r_status <= ST_OK;
            end
        end
    end

    always_comb begin
        o_stat.cls        = cls;
        o_stat.op         = op;
        o_stat.prev_digit = r_prev;
        o_stat.err_nz     = (r_err != ST_OK);
        o_stat.empty      = (r_depth == '0);
        o_stat.full       = (r_depth == DW'(STACK_DEPTH));
        o_stat.lt2        = (r_depth < DW'(2));
        o_stat.b_zero     = (r_top == '0);
        o_stat.b_neg      = r_top[W-1];
        o_stat.a_zero     = (r_rd == '0);
        o_stat.mul_done   = (r_my == '0);
        o_stat.div_done   = (r_dcnt == '0);
        o_stat.pe_zero    = (r_pe == '0);
        o_stat.pe_bit0    = r_pe[0];
        o_stat.pe_last    = (r_pe[W-1:1] == '0);
    end

    assign o_answer = r_answer;
    assign o_status = r_status;

endmodule

[src/pfe_ctrl.sv]
// Controller: sequences each symbol request through decode, stack access and
// the iterative units, and owns the output valid. Depends on pfe_pkg.
module pfe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  pfe_pkg::t_dp_stat  i_stat,
    output pfe_pkg::t_dp_cmd   o_cmd
);
    import pfe_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_sym = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                unique case (i_stat.cls)
                    SC_END: n_state = S_END;
                    SC_DIGIT: begin
                        o_cmd.prev_update = 1'b1;
                        if (!i_stat.err_nz) begin
                            if (i_stat.prev_digit && !i_stat.empty) begin
                                o_cmd.digit_acc = 1'b1;
                            end else if (i_stat.full) begin
                                o_cmd.set_err  = 1'b1;
                                o_cmd.err_code = ST_OVER;
                            end else begin
                                o_cmd.digit_push = 1'b1;
                            end
                        end
                    end
                    SC_OP: begin
                        o_cmd.prev_update = 1'b1;
                        if (!i_stat.err_nz) begin
                            if (i_stat.lt2) begin
                                o_cmd.set_err  = 1'b1;
                                o_cmd.err_code = ST_UNDER;
                            end else begin
                                o_cmd.rd_second = 1'b1;
                                n_state         = S_EXEC;
                            end
                        end
                    end
                    default: o_cmd.prev_update = 1'b1;
                endcase
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (i_stat.op)
                    OP_ADD: begin
                        o_cmd.pop     = 1'b1;
                        o_cmd.res_sel = RS_ADD;
                    end
                    OP_SUB: begin
                        o_cmd.pop     = 1'b1;
                        o_cmd.res_sel = RS_SUB;
                    end
                    OP_MUL: begin
                        o_cmd.mul_load = 1'b1;
                        o_cmd.mul_src  = MS_AB;
                        n_state        = S_MUL;
                    end
                    OP_DIV: begin
                        if (i_stat.b_zero) begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = ST_DIVZ;
                        end else begin
                            o_cmd.div_load = 1'b1;
                            n_state        = S_DIV;
                        end
                    end
                    OP_POW: begin
                        if (!i_stat.b_neg) begin
                            o_cmd.pow_load = 1'b1;
                            n_state        = S_POW;
                        end else if (i_stat.a_zero) begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = ST_ZPOW;
                        end else begin
                            o_cmd.pop     = 1'b1;
                            o_cmd.res_sel = RS_PNEG;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_MUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.pop     = 1'b1;
                    o_cmd.res_sel = RS_MUL;
                    n_state       = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.pop     = 1'b1;
                    o_cmd.res_sel = RS_DIV;
                    n_state       = S_IDLE;
                end
            end
            // square-and-multiply, low exponent bit first
            S_POW: begin
                if (i_stat.pe_zero) begin
                    o_cmd.pop     = 1'b1;
                    o_cmd.res_sel = RS_POW;
                    n_state       = S_IDLE;
                end else if (i_stat.pe_bit0) begin
                    o_cmd.mul_load = 1'b1;
                    o_cmd.mul_src  = MS_PR;
                    n_state        = S_PMUL;
                end else begin
                    o_cmd.mul_load = 1'b1;
                    o_cmd.mul_src  = MS_SQ;
                    n_state        = S_PSQ;
                end
            end
            S_PMUL: begin
                if (i_stat.mul_done) begin
                    if (i_stat.pe_last) begin
                        // last exponent bit: product is the answer, skip squaring
                        o_cmd.pop     = 1'b1;
                        o_cmd.res_sel = RS_MUL;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.pr_take  = 1'b1;
                        o_cmd.mul_load = 1'b1;
                        o_cmd.mul_src  = MS_SQ;
                        n_state        = S_PSQ;
                    end
                end
            end
            S_PSQ: begin
                if (i_stat.mul_done) begin
                    o_cmd.pb_take = 1'b1;
                    n_state       = S_POW;
                end
            end
            S_END: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.end_clear = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[tb/postfix_expression_evaluator_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the postfix expression evaluator: drives character requests,
// predicts each answer request and compares it. Needs pfe_pkg, pfe_if and the block RTL.
module postfix_expression_evaluator_test;
    import pfe_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 960;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int N_ROWS       = 7;

    typedef struct packed {
        logic signed [ANSWER_W-1:0] answer;
        t_status                    status;
    } t_answer;

    typedef struct {
        string   text;
        bit      typed;
        t_answer want;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pfe_sym_if sym_if ();
    pfe_res_if res_if ();

    postfix_expression_evaluator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sym   (sym_if),
        .o_res   (res_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Evaluator state as the bench sees it
    logic [VALUE_WIDTH_DEF-1:0] calc_stack [STACK_DEPTH_DEF];
    int                         calc_depth      = 0;
    bit                         calc_prev_digit = 1'b0;
    t_status                    calc_error      = ST_OK;

    t_answer answers_due [$];
    int      symbols_sent      = 0;
    int      expressions_ended = 0;
    int      faulted_answers   = 0;
    int      answers_checked   = 0;
    int      mismatch_cnt      = 0;
    int      cycle_cnt         = 0;
    int      long_hold         = 0;
    int      stall_left        = 0;
    bit      calm              = 1'b0;

    // Directed expressions; each is closed by a zero byte. Typed answers only where obvious.
    t_row directed_rows [N_ROWS] = '{
        '{"",                             1'b1, '{32'sd0, ST_UNDER}},
        '{"+7",                           1'b1, '{32'sd0, ST_UNDER}},
        '{"1 0/+",                        1'b1, '{32'sd0, ST_DIVZ}},
        '{"0 0 1-^",                      1'b1, '{32'sd0, ST_ZPOW}},
        '{"2147483648\3770 1-/",          1'b1, '{32'sh8000_0000, ST_OK}},
        '{"6 7*0 1-0 3-^+",               1'b0, '{32'sd0, ST_OK}},
        '{"7 0 2-/1 0 2-^3 0 1-^*0 0^+",  1'b0, '{32'sd0, ST_OK}}
    };

    function automatic bit is_digit(input logic [SYMBOL_W-1:0] c);
        return (c >= CH_DIG0) && (c <= CH_DIG9);
    endfunction

    function automatic bit is_operator(input logic [SYMBOL_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_CARET);
    endfunction

    function automatic void apply_operator(input logic [SYMBOL_W-1:0] c);
        logic [VALUE_WIDTH_DEF-1:0] a, b, r, ma, mb;
        if (calc_depth < 2) begin
            calc_error = ST_UNDER;
            return;
        end
        b = calc_stack[calc_depth-1];
        a = calc_stack[calc_depth-2];
        case (c)
            CH_PLUS:  r = a + b;
            CH_MINUS: r = a - b;
            CH_STAR:  r = a * b;
            CH_SLASH: begin
                if (b == 0) begin
                    calc_error = ST_DIVZ;
                    return;
                end
                ma = a[VALUE_WIDTH_DEF-1] ? -a : a;
                mb = b[VALUE_WIDTH_DEF-1] ? -b : b;
                r  = ma / mb;
                if (a[VALUE_WIDTH_DEF-1] != b[VALUE_WIDTH_DEF-1])
                    r = -r;
            end
            default: begin
                if (b[VALUE_WIDTH_DEF-1]) begin
                    // negative exponent: only +1 and -1 survive
                    if (a == 1)
                        r = 1;
                    else if (a == '1)
                        r = b[0] ? '1 : 1;
                    else if (a == 0) begin
                        calc_error = ST_ZPOW;
                        return;
                    end else
                        r = 0;
                end else begin
                    r  = 1;
                    ma = a;
                    mb = b;
                    while (mb != 0) begin
                        if (mb[0])
                            r = r * ma;
                        ma = ma * ma;
                        mb = mb >> 1;
                    end
                end
            end
        endcase
        calc_depth = calc_depth - 1;
        calc_stack[calc_depth-1] = r;
    endfunction

    function automatic void push_digit(input logic [SYMBOL_W-1:0] c);
        logic [VALUE_WIDTH_DEF-1:0] d;
        d = {24'd0, c - CH_DIG0};
        if (calc_prev_digit && calc_depth > 0)
            calc_stack[calc_depth-1] = calc_stack[calc_depth-1] * 10 + d;
        else if (calc_depth >= STACK_DEPTH_DEF)
            calc_error = ST_OVER;
        else begin
            calc_stack[calc_depth] = d;
            calc_depth = calc_depth + 1;
        end
    endfunction

    // Returns 1 when the character closes an expression and yields an answer.
    function automatic bit evaluate_symbol(input logic [SYMBOL_W-1:0] c, output t_answer res);
        bit digit;
        digit = is_digit(c);
        res   = '{answer: '0, status: ST_OK};
        if (c == CH_END) begin
            res.status = calc_error;
            if (calc_error == ST_OK) begin
                if (calc_depth == 0)
                    res.status = ST_UNDER;
                else
                    res.answer = calc_stack[calc_depth-1];
            end
            calc_depth      = 0;
            calc_prev_digit = 1'b0;
            calc_error      = ST_OK;
            return 1'b1;
        end
        if (calc_error == ST_OK) begin
            if (is_operator(c))
                apply_operator(c);
            else if (digit)
                push_digit(c);
        end
        calc_prev_digit = digit;
        return 1'b0;
    endfunction

    task automatic send_symbol(input logic [SYMBOL_W-1:0] c, input bit typed = 1'b0,
                               input t_answer want = '0);
        int      gap;
        t_answer got;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            sym_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sym_if.valid  <= 1'b1;
        sym_if.symbol <= c;
        @(posedge i_clk);
        while (!sym_if.ready)
            @(posedge i_clk);
        symbols_sent++;
        if (evaluate_symbol(c, got)) begin
            if (typed)
                got = want;
            answers_due.push_back(got);
            expressions_ended++;
            if (got.status != ST_OK)
                faulted_answers++;
        end
    endtask

    task automatic send_separator();
        logic [SYMBOL_W-1:0] c;
        if ($urandom_range(0, 3) != 0)
            c = " ";
        else begin
            c = 8'($urandom_range(1, 255));
            while (is_digit(c) || is_operator(c))
                c = 8'($urandom_range(1, 255));
        end
        send_symbol(c);
    endtask

    task automatic send_number();
        int n;
        case ($urandom_range(0, 19))
            0:             n = $urandom_range(10, 12);
            1, 2:          n = $urandom_range(4, 9);
            3, 4, 5, 6, 7: n = $urandom_range(2, 3);
            default:       n = 1;
        endcase
        if (calc_prev_digit)
            send_separator();
        repeat (n) send_symbol(8'(CH_DIG0 + $urandom_range(0, 9)));
    endtask

    task automatic send_operator();
        logic [SYMBOL_W-1:0] ops [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
        logic [SYMBOL_W-1:0] c;
        c = ops[$urandom_range(0, 4)];
        // long exponents keep the power loop busy; let few through
        if (c == CH_CARET && calc_error == ST_OK && calc_depth >= 2 &&
            !calc_stack[calc_depth-1][VALUE_WIDTH_DEF-1] && calc_stack[calc_depth-1] > 40 &&
            $urandom_range(0, 49) != 0)
            c = ops[$urandom_range(0, 3)];
        send_symbol(c);
    endtask

    task automatic send_expression();
        int live;
        int count;
        live  = 0;
        count = $urandom_range(1, 6);
        repeat (count) begin
            send_number();
            live++;
            if ($urandom_range(0, 1))
                send_separator();
            while (live >= 2 && $urandom_range(0, 2) == 0) begin
                send_operator();
                live--;
            end
        end
        while (live > 1 && $urandom_range(0, 7) != 0) begin
            send_operator();
            live--;
        end
        send_symbol(CH_END);
    endtask

    task automatic send_scramble(input bit raw);
        int n;
        n = $urandom_range(0, 14);
        repeat (n) begin
            if (raw)
                send_symbol(8'($urandom_range(1, 255)));
            else case ($urandom_range(0, 3))
                0:       send_operator();
                1:       send_separator();
                default: send_symbol(8'(CH_DIG0 + $urandom_range(0, 9)));
            endcase
        end
        send_symbol(CH_END);
    endtask

    // Fill the stack, work at the top of it, refill, then push once too often.
    task automatic send_deep_stack();
        repeat (STACK_DEPTH_DEF) begin
            if (calc_prev_digit)
                send_separator();
            send_symbol(8'(CH_DIG0 + $urandom_range(0, 9)));
        end
        repeat (3) send_operator();
        repeat (4) begin
            send_separator();
            send_symbol(8'(CH_DIG0 + $urandom_range(0, 9)));
        end
        send_operator();
        send_symbol(CH_END);
    endtask

    // Receiver: random back-pressure bursts, plus one long hold-off
    always @(negedge i_clk) begin
        if (long_hold > 0) begin
            res_if.ready <= 1'b0;
            long_hold = long_hold - 1;
        end else if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            res_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 8);
        end else
            res_if.ready <= 1'b1;
    end

    always @(posedge i_clk) begin : check_answers
        t_answer due;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (answers_due.size() == 0) begin
                $error("unexpected answer request: answer=%0d status=%0d",
                       res_if.answer, res_if.status);
                mismatch_cnt++;
            end else begin
                due = answers_due.pop_front();
                answers_checked++;
                if (res_if.answer !== due.answer) begin
                    $error("answer: expected %0d, got %0d", due.answer, res_if.answer);
                    mismatch_cnt++;
                end
                if (res_if.status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, res_if.status);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_cnt, answers_due.size());
            $display("postfix_expression_evaluator_test: errors");
            $finish;
        end
    end

    initial begin
        int random_start;
        bit deep_done;
        sym_if.valid  = 1'b0;
        sym_if.symbol = CH_END;
        res_if.ready  = 1'b0;
        deep_done     = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            for (int i = 0; i < directed_rows[r].text.len(); i++)
                send_symbol(directed_rows[r].text[i]);
            send_symbol(CH_END, directed_rows[r].typed, directed_rows[r].want);
        end

        random_start = symbols_sent;
        long_hold    = LONG_HOLD;
        while (symbols_sent - random_start < RANDOM_ITEMS) begin
            calm = (symbols_sent - random_start) > (RANDOM_ITEMS * 85 / 100);
            if (!deep_done && symbols_sent - random_start > 300) begin
                send_deep_stack();
                deep_done = 1'b1;
            end else case ($urandom_range(0, 19))
                0, 1:    send_scramble(1'b0);
                2:       send_scramble(1'b1);
                default: send_expression();
            endcase
        end

        @(negedge i_clk);
        sym_if.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d characters sent in %0d expressions, %0d answers checked",
                 symbols_sent, expressions_ended, answers_checked);
        $display("%0d expressions ended with an error status, %0d mismatches",
                 faulted_answers, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("postfix_expression_evaluator_test: clean");
        else
            $display("postfix_expression_evaluator_test: errors");
        $finish;
    end

endmodule

[postfix_expression_evaluator.f]
src/pfe_pkg.sv
src/pfe_if.sv
src/pfe_datapath.sv
src/pfe_ctrl.sv
src/postfix_expression_evaluator.sv
tb/postfix_expression_evaluator_test.sv
